@@ rtl/core/gww_pkg.sv @@
// Package for the greedy word wrap block: text constants, payload structs,
// cell control struct, sequencer states and small character helpers. No dependencies.
package gww_pkg;

	// Character codes
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_NEWLINE = 8'd10;

	// Width of the wrap width register
	localparam int CFG_W = 6;

	// Input request payload
	typedef struct packed {
		logic [7:0] in_char;
		logic       in_end;
	} gww_in_t;

	// Output request payload
	typedef struct packed {
		logic [7:0] out_char;
		logic       out_last;
	} gww_out_t;

	// Per-cell control: shift toward cell 0, or load the incoming byte
	typedef struct packed {
		logic shift;
		logic load;
	} gww_cell_ctrl_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_FIND1,
		ST_FIND2,
		ST_BREAK,
		ST_FLUSH,
		ST_TAIL,
		ST_DONE
	} gww_state_t;

	// Space or newline ends a long word
	function automatic logic is_break(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_NEWLINE);
	endfunction

	// Byte emitted for a character while a long word passes through
	function automatic logic [7:0] pass_char(input logic [7:0] c);
		return is_break(c) ? CH_NEWLINE : c;
	endfunction

endpackage

@@ rtl/core/greedy_word_wrap.sv @@
// Greedy word wrap top level: input/output registers, sequencer, cell chain.
// Depends on gww_pkg, gww_cell and gww_find.
//
// Text enters one byte per request and is reflowed to wrap_width columns
// (0 passes text through; widths above MAX_WIDTH act as MAX_WIDTH). The current
// line lives in a chain of MAX_WIDTH byte cells; bytes leave from cell 0 as the
// chain shifts, so the block emits at most one byte per cycle. A byte that is
// only stored, or that passes straight through, is finished in the head state
// when no earlier byte is pending. A byte that arrives at a full line starts a
// break: a space search through the states FIND1 and FIND2, then the line up to
// the last space and a newline are emitted, repeated while the line stays full.
// A newline or a final byte makes the block flush every held byte.
// The last output of each input request that emits a byte carries out_last.
// wrap_width may only be written while no request is in flight.
module greedy_word_wrap #(
	parameter int MAX_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wrap_valid,
	output logic                          wrap_ready,
	input  logic [gww_pkg::CFG_W-1:0]     wrap_width,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  gww_pkg::gww_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output gww_pkg::gww_out_t             out_data
);
	import gww_pkg::*;

	localparam int FW = $clog2(MAX_WIDTH + 1);

	// Configuration and request registers
	logic [CFG_W-1:0] width_q;
	gww_in_t          item_q;
	gww_state_t       state_q, state_d;
	logic [FW-1:0]    fill_q, fill_d;
	logic [FW-1:0]    cnt_q, cnt_d;
	logic             long_q, long_d;
	logic             tail_v_q, tail_v_d;
	logic [7:0]       tail_q, tail_d;
	logic             pe_v_q;
	logic [7:0]       pe_q;
	logic             out_valid_q;
	gww_out_t         out_q;

	// Sequencer controls
	logic             shift, append, prod, direct, push_last, done, in_acc;
	logic [7:0]       prod_char, direct_char;
	logic             out_free, prod_ok, take;
	logic [FW-1:0]    ew;
	logic [7:0]       c;
	logic             fin;

	// Cell chain and search
	gww_cell_ctrl_t   cell_ctrl [MAX_WIDTH];
	logic [7:0]       cell_data [MAX_WIDTH];
	logic [7:0]       cell_nbr  [MAX_WIDTH];
	logic [MAX_WIDTH-1:0] cell_sp;
	logic [MAX_WIDTH-1:0] sp_mask;
	logic             found_s2;
	logic [FW-1:0]    pos_s2;

	assign ew = (width_q > CFG_W'(MAX_WIDTH)) ? FW'(MAX_WIDTH) : FW'(width_q);
	assign c   = item_q.in_char;
	assign fin = item_q.in_end;

	assign out_free = !out_valid_q || !out_stall;
	assign prod_ok  = !pe_v_q || out_free;
	assign take     = pe_v_q || out_free;

	// Line buffer cells
	for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
		if (i == MAX_WIDTH - 1) begin : g_end
			assign cell_nbr[i] = 8'h00;
		end else begin : g_mid
			assign cell_nbr[i] = cell_data[i+1];
		end
		assign cell_ctrl[i] = '{shift: shift, load: append && (fill_q == FW'(i))};
		assign sp_mask[i]   = cell_sp[i] && (FW'(i) < ew);

		gww_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl[i]),
			.nbr      (cell_nbr[i]),
			.wdata    (c),
			.data     (cell_data[i]),
			.is_space (cell_sp[i])
		);
	end

	gww_find #(.N(MAX_WIDTH)) u_find (
		.clk      (clk),
		.mask     (sp_mask),
		.found_s2 (found_s2),
		.pos_s2   (pos_s2)
	);

	// Next state and per-cycle controls
	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		cnt_d       = cnt_q;
		long_d      = long_q;
		tail_v_d    = tail_v_q;
		tail_d      = tail_q;
		shift       = 1'b0;
		append      = 1'b0;
		prod        = 1'b0;
		prod_char   = '0;
		direct      = 1'b0;
		direct_char = '0;
		push_last   = 1'b0;
		done        = 1'b0;

		case (state_q)
			ST_IDLE: begin
			end
			ST_HEAD: begin
				if (ew == '0) begin
					// pass-through: drain held line, then the byte itself
					if (fill_q != '0) begin
						long_d   = 1'b0;
						tail_v_d = 1'b1;
						tail_d   = c;
						state_d  = ST_FLUSH;
					end else if (take) begin
						long_d      = 1'b0;
						direct      = !pe_v_q;
						direct_char = c;
						done        = !pe_v_q;
						tail_v_d    = 1'b1;
						tail_d      = c;
						if (pe_v_q) begin
							state_d = ST_TAIL;
						end
					end
				end else if (long_q) begin
					// long word passing through
					if (take) begin
						long_d      = !is_break(c) && !fin;
						direct      = !pe_v_q;
						direct_char = pass_char(c);
						done        = !pe_v_q;
						tail_v_d    = 1'b1;
						tail_d      = pass_char(c);
						if (pe_v_q) begin
							state_d = ST_TAIL;
						end
					end
				end else if (fill_q >= ew) begin
					state_d = ST_FIND1;
				end else if (c == CH_NEWLINE) begin
					if (fill_q != '0) begin
						tail_v_d = 1'b1;
						tail_d   = CH_NEWLINE;
						state_d  = ST_FLUSH;
					end else if (take) begin
						direct      = !pe_v_q;
						direct_char = CH_NEWLINE;
						done        = !pe_v_q;
						tail_v_d    = 1'b1;
						tail_d      = CH_NEWLINE;
						if (pe_v_q) begin
							state_d = ST_TAIL;
						end
					end
				end else begin
					// store the byte at the end of the line
					append = 1'b1;
					fill_d = fill_q + 1'b1;
					if (fin) begin
						tail_v_d = 1'b0;
						state_d  = ST_FLUSH;
					end else if (pe_v_q) begin
						state_d = ST_DONE;
					end else begin
						done = 1'b1;
					end
				end
			end
			ST_FIND1: begin
				state_d = ST_FIND2;
			end
			ST_FIND2: begin
				if (found_s2) begin
					cnt_d   = pos_s2;
					state_d = ST_BREAK;
				end else begin
					// no space in the line: emit it, then the byte, and start long-word mode unless the byte ends the word or the text
					long_d   = !is_break(c) && !fin;
					tail_v_d = 1'b1;
					tail_d   = pass_char(c);
					state_d  = ST_FLUSH;
				end
			end
			ST_BREAK: begin
				if (prod_ok) begin
					prod   = 1'b1;
					shift  = 1'b1;
					fill_d = fill_q - 1'b1;
					if (cnt_q != '0) begin
						prod_char = cell_data[0];
						cnt_d     = cnt_q - 1'b1;
					end else begin
						prod_char = CH_NEWLINE;
						state_d   = ST_HEAD;
					end
				end
			end
			ST_FLUSH: begin
				if (prod_ok) begin
					prod      = 1'b1;
					prod_char = cell_data[0];
					shift     = 1'b1;
					fill_d    = fill_q - 1'b1;
					if (fill_q == FW'(1)) begin
						state_d = tail_v_q ? ST_TAIL : ST_DONE;
					end
				end
			end
			ST_TAIL: begin
				if (prod_ok) begin
					prod      = 1'b1;
					prod_char = tail_q;
					state_d   = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!pe_v_q) begin
					done = 1'b1;
				end else if (out_free) begin
					push_last = 1'b1;
					done      = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		in_stall = (state_q != ST_IDLE) && !done;
		in_acc   = in_valid && !in_stall;
		if (in_acc) begin
			state_d = ST_HEAD;
		end else if (done) begin
			state_d = ST_IDLE;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= CFG_W'(32);
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			cnt_q       <= '0;
			long_q      <= 1'b0;
			tail_v_q    <= 1'b0;
			pe_v_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wrap_valid) begin
				width_q <= wrap_width;
			end
			state_q  <= state_d;
			fill_q   <= fill_d;
			cnt_q    <= cnt_d;
			long_q   <= long_d;
			tail_v_q <= tail_v_d;
			if (prod) begin
				pe_v_q <= 1'b1;
			end else if (push_last) begin
				pe_v_q <= 1'b0;
			end
			if (direct || (prod && pe_v_q) || push_last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_data;
		end
		tail_q <= tail_d;
		if (prod) begin
			pe_q <= prod_char;
		end
		if (direct) begin
			out_q <= '{out_char: direct_char, out_last: 1'b1};
		end else if (prod && pe_v_q) begin
			out_q <= '{out_char: pe_q, out_last: 1'b0};
		end else if (push_last) begin
			out_q <= '{out_char: pe_q, out_last: 1'b1};
		end
	end

	assign wrap_ready = 1'b1;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	// Checks
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(MAX_WIDTH))
		else $error("line fill above buffer depth");

	// the line may still be draining while long-word mode is already set
	a_long_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(long_q && (state_q == ST_HEAD)) |-> (fill_q == '0))
		else $error("long-word mode with bytes held");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pe_v_q)
		else $error("pending byte left after request finished");

	a_break_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BREAK) |-> (cnt_q < fill_q))
		else $error("break point beyond held line");

endmodule

@@ rtl/core/gww_cell.sv @@
// One byte cell of the line buffer chain.
// Depends on gww_pkg for the cell control struct and the space code.
module gww_cell (
	input  logic                    clk,
	input  gww_pkg::gww_cell_ctrl_t ctrl,
	input  logic [7:0]              nbr,
	input  logic [7:0]              wdata,
	output logic [7:0]              data,
	output logic                    is_space
);
	import gww_pkg::*;

	logic [7:0] data_q;

	// Shift from the right-hand neighbor, or take the appended byte
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= nbr;
		end else if (ctrl.load) begin
			data_q <= wdata;
		end
	end

	assign data     = data_q;
	assign is_space = (data_q == CH_SPACE);

endmodule

@@ rtl/core/gww_find.sv @@
// Two-stage registered search for the highest set bit of the space mask.
// Self-contained; groups of eight cells are reduced first, then the groups.
module gww_find #(
	parameter int N = 32
) (
	input  logic                     clk,
	input  logic [N-1:0]             mask,
	output logic                     found_s2,
	output logic [$clog2(N+1)-1:0]   pos_s2
);
	localparam int NG   = (N + 7) / 8;
	localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
	localparam int FW   = $clog2(N + 1);
	localparam int PADW = NG * 8;

	logic [PADW-1:0] mask_pad;
	logic [NG-1:0]   any_s1;
	logic [2:0]      idx_s1 [NG];
	logic            found_c;
	logic [GW+2:0]   pos_c;

	// Highest set bit within one group of eight
	function automatic logic [2:0] last8(input logic [7:0] m);
		logic [2:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (m[i]) begin
				r = 3'(i);
			end
		end
		return r;
	endfunction

	assign mask_pad = PADW'(mask);

	// Stage 1: per-group reduction
	always_ff @(posedge clk) begin
		for (int g = 0; g < NG; g++) begin
			any_s1[g] <= |mask_pad[g*8 +: 8];
			idx_s1[g] <= last8(mask_pad[g*8 +: 8]);
		end
	end

	// Stage 2: highest group with a hit
	always_comb begin
		found_c = |any_s1;
		pos_c   = '0;
		for (int g = 0; g < NG; g++) begin
			if (any_s1[g]) begin
				pos_c = {GW'(g), idx_s1[g]};
			end
		end
	end

	always_ff @(posedge clk) begin
		found_s2 <= found_c;
		pos_s2   <= FW'(pos_c);
	end

endmodule

@@ dv/gww_checker.sv @@
// Scoreboard for the greedy word wrap block: watches the config, input and output channels,
// predicts the wrapped byte stream and compares it with what the block emits.
// Depends on gww_pkg.
module gww_checker #(
	parameter int MAX_W = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wrap_valid,
	input  logic                      wrap_ready,
	input  logic [gww_pkg::CFG_W-1:0] wrap_width,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  gww_pkg::gww_in_t          in_data,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  gww_pkg::gww_out_t         out_data,
	output int                        fails,
	output int                        pending,
	output int                        taken,
	output int                        emitted
);
	import gww_pkg::*;

	// Predicted line state
	logic [7:0]              line_buf [MAX_W];
	int                      held;
	bit                      in_long_word;
	logic [CFG_W-1:0]        width_reg;
	gww_out_t                wrapped_q [$];
	gww_out_t                want;

	task automatic push_byte(input logic [7:0] c);
		gww_out_t r;
		r.out_char = c;
		r.out_last = 1'b0;
		wrapped_q.push_back(r);
	endtask

	// Emit every held byte and empty the line
	task automatic flush_line();
		for (int i = 0; i < held; i++)
			push_byte(line_buf[i]);
		held = 0;
	endtask

	// Long word: bytes pass, a space or newline ends it as a newline
	task automatic pass_long(input logic [7:0] c);
		if (c == CH_SPACE || c == CH_NEWLINE) begin
			push_byte(CH_NEWLINE);
			in_long_word = 1'b0;
		end else begin
			push_byte(c);
		end
	endtask

	// Expected output bytes for one text byte
	task automatic reflow_byte(input gww_in_t req);
		int       eff;
		int       p;
		int       base;
		bit       found;
		gww_out_t tail;
		base = wrapped_q.size();
		eff = (width_reg > MAX_W) ? MAX_W : int'(width_reg);
		if (held > MAX_W)
			held = MAX_W;
		if (eff == 0) begin
			flush_line();
			in_long_word = 1'b0;
			push_byte(req.in_char);
		end else if (in_long_word) begin
			pass_long(req.in_char);
		end else begin
			// break at the last space inside the width while the line is full
			while (held >= eff) begin
				p = eff;
				found = 1'b0;
				while (p > 0) begin
					p--;
					if (line_buf[p] == CH_SPACE) begin
						found = 1'b1;
						break;
					end
				end
				if (!found) begin
					flush_line();
					in_long_word = 1'b1;
					break;
				end
				for (int i = 0; i < p; i++)
					push_byte(line_buf[i]);
				push_byte(CH_NEWLINE);
				for (int i = 0; i < held - p - 1; i++)
					line_buf[i] = line_buf[i + p + 1];
				held -= p + 1;
			end
			if (in_long_word) begin
				pass_long(req.in_char);
			end else if (req.in_char == CH_NEWLINE) begin
				flush_line();
				push_byte(CH_NEWLINE);
			end else if (held < MAX_W) begin
				line_buf[held] = req.in_char;
				held++;
			end
		end
		if (req.in_end) begin
			flush_line();
			in_long_word = 1'b0;
		end
		// mark the last byte caused by this request
		if (wrapped_q.size() > base) begin
			tail = wrapped_q.pop_back();
			tail.out_last = 1'b1;
			wrapped_q.push_back(tail);
		end
	endtask

	// Sample all channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			in_long_word = 1'b0;
			width_reg = 6'd32;
			wrapped_q.delete();
			pending = 0;
		end else begin
			if (wrap_valid && wrap_ready)
				width_reg = wrap_width;
			if (in_valid && !in_stall) begin
				taken++;
				reflow_byte(in_data);
			end
			if (out_valid && !out_stall) begin
				emitted++;
				if (wrapped_q.size() == 0) begin
					$error("unexpected output byte %0h (last %0b)", out_data.out_char,
						out_data.out_last);
					fails++;
				end else begin
					want = wrapped_q.pop_front();
					if (out_data.out_char !== want.out_char) begin
						$error("out_char: expected %0h, got %0h", want.out_char,
							out_data.out_char);
						fails++;
					end
					if (out_data.out_last !== want.out_last) begin
						$error("out_last: expected %0b, got %0b", want.out_last,
							out_data.out_last);
						fails++;
					end
				end
			end
			pending = wrapped_q.size();
		end
	end

endmodule

@@ dv/tb.sv @@
// Testbench top for greedy_word_wrap: clock, reset, text stimulus, width writes and verdict.
// Depends on gww_pkg, greedy_word_wrap and gww_checker.
module tb;
	import gww_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 64;

	logic              clk;
	logic              arst_n;
	logic              wrap_valid;
	logic              wrap_ready;
	logic [CFG_W-1:0]  wrap_width;
	logic              in_valid;
	logic              in_stall;
	gww_in_t           in_data;
	logic              out_valid;
	logic              out_stall;
	gww_out_t          out_data;

	int fails;
	int pending;
	int taken;
	int emitted;
	int tx_idle_pct;
	int rx_idle_pct;
	int cycle_count;
	int widths_used;
	int word_left;

	greedy_word_wrap dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.wrap_valid (wrap_valid),
		.wrap_ready (wrap_ready),
		.wrap_width (wrap_width),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	gww_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.wrap_valid (wrap_valid),
		.wrap_ready (wrap_ready),
		.wrap_width (wrap_width),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.fails      (fails),
		.pending    (pending),
		.taken      (taken),
		.emitted    (emitted)
	);

	// 12-unit clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Random receiver stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// One text byte; stall is read at the falling edge where it is stable
	task automatic send_byte(input logic [7:0] c, input logic fin);
		int   gap;
		logic stalled;
		gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{in_char: c, in_end: fin};
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
	endtask

	task automatic send_str(input string s, input logic fin_on_last);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], fin_on_last && (i == s.len() - 1));
	endtask

	// Hold off until every predicted byte has come out
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// Idle point: drained plus room for a request that emits nothing
	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(input logic [CFG_W-1:0] w);
		logic rdy;
		wrap_valid <= 1'b1;
		wrap_width <= w;
		do begin
			@(negedge clk);
			rdy = wrap_ready;
			@(posedge clk);
		end while (!rdy);
		wrap_valid <= 1'b0;
		widths_used++;
	endtask

	// Random text: words of letters, some long, some stray bytes, occasional final byte
	task automatic send_text(input int n_items);
		logic [7:0] c;
		for (int i = 0; i < n_items; i++) begin
			if (i == n_items / 2)
				drain();
			if (word_left == 0) begin
				c = ($urandom_range(7) == 0) ? CH_NEWLINE : CH_SPACE;
				word_left = ($urandom_range(5) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 8);
			end else begin
				c = ($urandom_range(15) == 0) ? 8'($urandom_range(255))
					: 8'(97 + $urandom_range(25));
				word_left--;
			end
			send_byte(c, $urandom_range(29) == 0);
		end
	endtask

	initial begin
		logic [CFG_W-1:0] plan [9];
		plan = '{6'd63, 6'd5, 6'd1, 6'd16, 6'd0, 6'd3, 6'd32, 6'd12, 6'd2};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		wrap_valid = 1'b0;
		wrap_width = '0;
		out_stall = 1'b0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		cycle_count = 0;
		widths_used = 0;
		word_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: break at a space, newline flush, long word, byte extremes
		write_width(6'd4);
		send_str("ab cd", 1'b0);
		send_byte(CH_NEWLINE, 1'b0);
		send_str("wxyzQ ", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		// width lowered under the fill: repeated breaks
		send_str("a b ", 1'b0);
		settle();
		write_width(6'd2);
		send_byte("c", 1'b1);
		// width zero: held bytes out, then pass-through
		send_str("hi", 1'b0);
		settle();
		write_width(6'd0);
		send_byte("A", 1'b0);
		send_byte(CH_SPACE, 1'b1);
		settle();

		// Random text under three idling regimes and several widths
		for (int r = 0; r < 3; r++) begin
			tx_idle_pct = (r == 0) ? 11 : (r == 1) ? 65 : 0;
			rx_idle_pct = (r == 0) ? 65 : (r == 1) ? 11 : 0;
			for (int k = 0; k < 3; k++) begin
				write_width(plan[r * 3 + k]);
				send_text(34);
				settle();
			end
		end

		@(negedge clk);
		$display("Covered %0d text bytes, %0d wrapped bytes out, %0d width settings.",
			taken, emitted, widths_used);
		if (fails == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/gww_pkg.sv
rtl/core/gww_cell.sv
rtl/core/gww_find.sv
rtl/core/greedy_word_wrap.sv
dv/gww_checker.sv
dv/tb.sv
